### src/mahd_pkg.sv
// mahd_pkg: types, header codes and rate tables for the mpeg audio header decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none
package mahd_pkg;

	// version field codes in the header word
	localparam logic [1:0] VCODE_25       = 2'd0;
	localparam logic [1:0] VCODE_RESERVED = 2'd1;
	localparam logic [1:0] VCODE_2        = 2'd2;

	// decoded version numbering on the result
	localparam logic [1:0] VER_25 = 2'd0;
	localparam logic [1:0] VER_2  = 2'd1;
	localparam logic [1:0] VER_1  = 2'd2;

	// layer field codes
	localparam logic [1:0] LCODE_RESERVED = 2'd0;
	localparam logic [1:0] LCODE_L3       = 2'd1;
	localparam logic [1:0] LCODE_L2       = 2'd2;

	localparam logic [3:0] BRX_FREE = 4'd0;
	localparam logic [3:0] BRX_BAD  = 4'd15;
	localparam logic [1:0] SRX_BAD  = 2'd3;
	localparam logic [1:0] CM_MONO  = 2'd3;

	localparam int NumW   = 26;
	localparam int RecipW = 25;
	localparam int QuotW  = 21;
	localparam int RecipShift = 26;

	// frame size numerator scale
	localparam logic [NumW-1:0] SIZE_SCALE = 26'd144000;

	// free format: divisors after the power-of-two part has been shifted out
	localparam logic [15:0] FREE_DIV_V1 = 16'd3;
	localparam logic [15:0] FREE_DIV_V2 = 16'd9;
	localparam logic [NumW-1:0] FREE_ROUND_V1 = 26'd11;
	localparam logic [NumW:0]   FREE_ROUND_V2 = 27'd143;

	// reciprocals floor(2^26 / d)
	localparam logic [RecipW-1:0] RECIP_44100 = 25'd1521;
	localparam logic [RecipW-1:0] RECIP_48000 = 25'd1398;
	localparam logic [RecipW-1:0] RECIP_32000 = 25'd2097;
	localparam logic [RecipW-1:0] RECIP_3     = 25'd22369621;
	localparam logic [RecipW-1:0] RECIP_9     = 25'd7456540;

	localparam logic [15:0] FS_44100 = 16'd44100;
	localparam logic [15:0] FS_48000 = 16'd48000;
	localparam logic [15:0] FS_32000 = 16'd32000;

	typedef struct packed {
		logic        ok;
		logic [1:0]  version;
		logic [1:0]  layer;
		logic [10:0] spf;
		logic [15:0] fs;
		logic [1:0]  cm;
		logic [1:0]  nch;
		logic [5:0]  xoff;
		logic        free_fmt;
		logic        pad;
		logic [8:0]  br_tab;
	} hdr_info_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} div_en_t;

	function automatic logic [8:0] rate_v1(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd1:    r = 9'd32;
			4'd2:    r = 9'd40;
			4'd3:    r = 9'd48;
			4'd4:    r = 9'd56;
			4'd5:    r = 9'd64;
			4'd6:    r = 9'd80;
			4'd7:    r = 9'd96;
			4'd8:    r = 9'd112;
			4'd9:    r = 9'd128;
			4'd10:   r = 9'd160;
			4'd11:   r = 9'd192;
			4'd12:   r = 9'd224;
			4'd13:   r = 9'd256;
			4'd14:   r = 9'd320;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] rate_v2(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd1:    r = 9'd8;
			4'd2:    r = 9'd16;
			4'd3:    r = 9'd24;
			4'd4:    r = 9'd32;
			4'd5:    r = 9'd40;
			4'd6:    r = 9'd48;
			4'd7:    r = 9'd56;
			4'd8:    r = 9'd64;
			4'd9:    r = 9'd80;
			4'd10:   r = 9'd96;
			4'd11:   r = 9'd112;
			4'd12:   r = 9'd128;
			4'd13:   r = 9'd144;
			4'd14:   r = 9'd160;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] fs_of(input logic [1:0] idx);
		logic [15:0] f;
		case (idx)
			2'd0:    f = FS_44100;
			2'd1:    f = FS_48000;
			2'd2:    f = FS_32000;
			default: f = 16'd0;
		endcase
		return f;
	endfunction

	function automatic logic [RecipW-1:0] recip_of_fs(input logic [15:0] f);
		logic [RecipW-1:0] m;
		case (f)
			FS_44100: m = RECIP_44100;
			FS_48000: m = RECIP_48000;
			FS_32000: m = RECIP_32000;
			default:  m = '0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### src/mahd_decode.sv
// mahd_decode: stage 1, header field checks and table lookups
// depends on mahd_pkg
`timescale 1ns / 1ps
`default_nettype none
module mahd_decode (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [31:0]      header_word,
	output mahd_pkg::hdr_info_t   info_s1
);
	import mahd_pkg::*;

	hdr_info_t info;
	logic [1:0] vcode;
	logic [1:0] lcode;
	logic [3:0] brx;
	logic [1:0] srx;
	logic       mpeg1;
	logic       good;

	always_comb begin
		vcode = header_word[20:19];
		lcode = header_word[18:17];
		brx   = header_word[15:12];
		srx   = header_word[11:10];
		mpeg1 = (vcode != VCODE_25) && (vcode != VCODE_2);
		good  = (header_word[31:21] == 11'h7FF) && (vcode != VCODE_RESERVED) &&
		        (lcode != LCODE_RESERVED) && (brx != BRX_BAD) && (srx != SRX_BAD);

		info = '0;
		info.ok = good;
		case (vcode)
			VCODE_25: info.version = VER_25;
			VCODE_2:  info.version = VER_2;
			default:  info.version = VER_1;
		endcase
		case (lcode)
			LCODE_L3: begin
				info.layer = 2'd3;
				info.spf   = mpeg1 ? 11'd1152 : 11'd576;
			end
			LCODE_L2: begin
				info.layer = 2'd2;
				info.spf   = 11'd1152;
			end
			default: begin
				info.layer = 2'd1;
				info.spf   = 11'd384;
			end
		endcase
		info.fs       = fs_of(srx);
		info.pad      = header_word[9];
		info.cm       = header_word[7:6];
		info.nch      = (info.cm == CM_MONO) ? 2'd1 : 2'd2;
		if (mpeg1)
			info.xoff = (info.cm == CM_MONO) ? 6'd21 : 6'd36;
		else
			info.xoff = (info.cm == CM_MONO) ? 6'd13 : 6'd21;
		info.free_fmt = (brx == BRX_FREE);
		info.br_tab   = mpeg1 ? rate_v1(brx) : rate_v2(brx);
		// rejected words carry nothing downstream
		if (!good)
			info = '0;
	end

	always_ff @(posedge clk) begin
		if (en)
			info_s1 <= info;
	end

endmodule
`default_nettype wire

### src/mahd_numer.sv
// mahd_numer: stage 2, builds dividend, divisor and reciprocal for the shared divider
// depends on mahd_pkg
`timescale 1ns / 1ps
`default_nettype none
module mahd_numer (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire mahd_pkg::hdr_info_t            info_s1,
	output logic [mahd_pkg::NumW-1:0]           n_s2,
	output logic [15:0]                         d_s2,
	output logic [mahd_pkg::RecipW-1:0]         m_s2
);
	import mahd_pkg::*;

	logic [8:0]      spf_q4;
	logic [10:0]     spf_m;
	logic [NumW:0]   x_free;
	logic [NumW-1:0] n_nxt;
	logic [15:0]     d_nxt;
	logic [RecipW-1:0] m_nxt;
	logic            mpeg1;

	always_comb begin
		mpeg1  = (info_s1.version == VER_1);
		spf_q4 = info_s1.spf[10:2] - {8'd0, info_s1.pad};
		spf_m  = info_s1.spf - {10'd0, info_s1.pad};
		if (!info_s1.free_fmt) begin
			x_free = '0;
			n_nxt  = NumW'({17'd0, info_s1.br_tab}) * SIZE_SCALE;
			d_nxt  = info_s1.fs;
			m_nxt  = recip_of_fs(info_s1.fs);
		end else if (mpeg1) begin
			// divide by 12 as a shift by two and then by 3
			x_free = (27'(spf_q4) * 27'(info_s1.fs)) + 27'(FREE_ROUND_V1);
			n_nxt  = {1'b0, x_free[NumW:2]};
			d_nxt  = FREE_DIV_V1;
			m_nxt  = RECIP_3;
		end else begin
			// divide by 144 as a shift by four and then by 9
			x_free = (27'(spf_m) * 27'(info_s1.fs)) + FREE_ROUND_V2;
			n_nxt  = {3'd0, x_free[NumW:4]};
			d_nxt  = FREE_DIV_V2;
			m_nxt  = RECIP_9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= n_nxt;
			d_s2 <= d_nxt;
			m_s2 <= m_nxt;
		end
	end

endmodule
`default_nettype wire

### src/mahd_divider.sv
// mahd_divider: stages 3 to 5, reciprocal multiply, back multiply, one-step correction
// depends on mahd_pkg
`timescale 1ns / 1ps
`default_nettype none
module mahd_divider (
	input  wire logic                           clk,
	input  wire mahd_pkg::div_en_t              en,
	input  wire logic [mahd_pkg::NumW-1:0]      n_s2,
	input  wire logic [15:0]                    d_s2,
	input  wire logic [mahd_pkg::RecipW-1:0]    m_s2,
	output logic [mahd_pkg::QuotW-1:0]          q_s5
);
	import mahd_pkg::*;

	localparam int ProdW = NumW + RecipW;
	localparam int BackW = QuotW + 16;

	logic [ProdW-1:0] prod_s3;
	logic [NumW-1:0]  n_s3, n_s4;
	logic [15:0]      d_s3, d_s4;
	logic [QuotW-1:0] q0_s4;
	logic [NumW-1:0]  qd_s4;

	logic [QuotW-1:0] q0;
	logic [BackW-1:0] qd_full;
	logic [NumW-1:0]  rem;

	always_comb begin
		// estimate is exact or one low since the dividend stays below 2^26
		q0      = prod_s3[RecipShift +: QuotW];
		qd_full = BackW'(q0) * BackW'(d_s3);
		rem     = n_s4 - qd_s4;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= ProdW'(n_s2) * ProdW'(m_s2);
			n_s3    <= n_s2;
			d_s3    <= d_s2;
		end
		if (en.s4) begin
			q0_s4 <= q0;
			qd_s4 <= qd_full[NumW-1:0];
			n_s4  <= n_s3;
			d_s4  <= d_s3;
		end
		if (en.s5)
			q_s5 <= q0_s4 + QuotW'(rem >= NumW'(d_s4));
	end

endmodule
`default_nettype wire

### src/mpeg_audio_header_decode.sv
// mpeg_audio_header_decode: top level, five-stage pipeline and its flow control
// depends on mahd_pkg, mahd_decode, mahd_numer, mahd_divider
`timescale 1ns / 1ps
`default_nettype none
// Decodes one 32-bit MPEG audio frame header per transfer. A new header word is
// taken every cycle while in_stall is low; each result passes through stages s1 to s5
// and transfers from s5 when the output is not stalled.
// The stages are field decode, dividend build,
// reciprocal multiply, back multiply and quotient correction; the frame size and
// the free-format bit rate share that one divider path. Each stage holds its
// item while the stage after it is full and stalled, so a stall on the output
// fills empty stages first before in_stall rises. Rejected headers give a result
// with every field zero.
module mpeg_audio_header_decode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] header_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             valid_res,
	output logic [10:0]      size_result,
	output logic [1:0]       version,
	output logic [1:0]       layer,
	output logic [10:0]      samples_per_frame,
	output logic [15:0]      sample_rate,
	output logic [1:0]       channel_mode,
	output logic [1:0]       num_channels,
	output logic [5:0]       xing_offset,
	output logic [20:0]      bit_rate
);
	import mahd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	div_en_t div_en;

	hdr_info_t info_s1, info_s2, info_s3, info_s4, info_s5;
	logic [NumW-1:0]   n_s2;
	logic [15:0]       d_s2;
	logic [RecipW-1:0] m_s2;
	logic [QuotW-1:0]  q_s5;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		rdy5 = !v_s5 || !out_stall;
		rdy4 = !v_s4 || rdy5;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		in_stall  = !rdy1;
		div_en.s3 = rdy3;
		div_en.s4 = rdy4;
		div_en.s5 = rdy5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) info_s2 <= info_s1;
		if (rdy3) info_s3 <= info_s2;
		if (rdy4) info_s4 <= info_s3;
		if (rdy5) info_s5 <= info_s4;
	end

	mahd_decode u_decode (
		.clk         (clk),
		.en          (rdy1),
		.header_word (header_word),
		.info_s1     (info_s1)
	);

	mahd_numer u_numer (
		.clk     (clk),
		.en      (rdy2),
		.info_s1 (info_s1),
		.n_s2    (n_s2),
		.d_s2    (d_s2),
		.m_s2    (m_s2)
	);

	mahd_divider u_divider (
		.clk  (clk),
		.en   (div_en),
		.n_s2 (n_s2),
		.d_s2 (d_s2),
		.m_s2 (m_s2),
		.q_s5 (q_s5)
	);

	always_comb begin
		out_valid = v_s5;
		if (info_s5.ok) begin
			valid_res         = 1'b1;
			size_result       = info_s5.free_fmt ? 11'd1 : (q_s5[10:0] + {10'd0, info_s5.pad});
			bit_rate          = info_s5.free_fmt ? q_s5 : {12'd0, info_s5.br_tab};
			version           = info_s5.version;
			layer             = info_s5.layer;
			samples_per_frame = info_s5.spf;
			sample_rate       = info_s5.fs;
			channel_mode      = info_s5.cm;
			num_channels      = info_s5.nch;
			xing_offset       = info_s5.xoff;
		end else begin
			valid_res         = 1'b0;
			size_result       = '0;
			bit_rate          = '0;
			version           = '0;
			layer             = '0;
			samples_per_frame = '0;
			sample_rate       = '0;
			channel_mode      = '0;
			num_channels      = '0;
			xing_offset       = '0;
		end
	end

`ifndef SYNTHESIS
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> size_result != 11'd0 && size_result <= 11'd1441)
		else $error("valid header with out-of-range frame size");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> size_result == 11'd0 && bit_rate == 21'd0)
		else $error("rejected header with nonzero size or rate");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall |-> in_stall)
		else $error("full pipeline not stalling input");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transfer lost at stage 1");
`endif

endmodule
`default_nettype wire

### dv/testbench.sv
// testbench for mpeg_audio_header_decode: directed and random header words checked
// against a field-level decoder model; depends on mahd_pkg and the decoder rtl
`timescale 1ns / 1ps
module testbench;
	import mahd_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] VCODE_1  = 2'd3;
	localparam logic [1:0] LCODE_L1 = 2'd3;

	// kbps per bitrate index, index 0 in the low bits
	localparam logic [134:0] KBPS_V1 = {9'd320, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128,
		9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd0};
	localparam logic [134:0] KBPS_V2 = {9'd160, 9'd144, 9'd128, 9'd112, 9'd96, 9'd80,
		9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd24, 9'd16, 9'd8, 9'd0};
	localparam logic [47:0] RATE_HZ = {16'd32000, 16'd48000, 16'd44100};

	typedef struct packed {
		logic        ok;
		logic [10:0] frame_bytes;
		logic [1:0]  ver;
		logic [1:0]  lay;
		logic [10:0] spf;
		logic [15:0] fs;
		logic [1:0]  cm;
		logic [1:0]  nch;
		logic [5:0]  xoff;
		logic [20:0] kbps;
	} frame_info_t;

	typedef struct {
		logic [31:0] word;
		frame_info_t info;
	} pending_frame_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] header_word;
	logic        out_valid;
	logic        out_stall;
	logic        valid_res;
	logic [10:0] size_result;
	logic [1:0]  version;
	logic [1:0]  layer;
	logic [10:0] samples_per_frame;
	logic [15:0] sample_rate;
	logic [1:0]  channel_mode;
	logic [1:0]  num_channels;
	logic [5:0]  xing_offset;
	logic [20:0] bit_rate;

	pending_frame_t pending_frames[$];
	pending_frame_t head;
	int errors = 0;
	int n_sent = 0;
	int n_valid = 0;
	int n_free = 0;
	int n_reject = 0;
	int input_held = 0;
	int hold_req = 0;
	bit no_idle = 1'b0;

	mpeg_audio_header_decode DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.header_word       (header_word),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.valid_res         (valid_res),
		.size_result       (size_result),
		.version           (version),
		.layer             (layer),
		.samples_per_frame (samples_per_frame),
		.sample_rate       (sample_rate),
		.channel_mode      (channel_mode),
		.num_channels      (num_channels),
		.xing_offset       (xing_offset),
		.bit_rate          (bit_rate)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic frame_info_t decode_frame_header(input logic [31:0] w);
		frame_info_t r;
		logic [1:0]  vcode;
		logic [1:0]  lcode;
		logic [3:0]  brx;
		logic [1:0]  srx;
		logic        pad;
		logic        is_v1;
		logic        mono;
		int unsigned fs;
		int unsigned spf;
		int unsigned rate;
		r = '0;
		vcode = w[20:19];
		lcode = w[18:17];
		brx = w[15:12];
		srx = w[11:10];
		pad = w[9];
		if (w[31:21] != 11'h7FF || vcode == VCODE_RESERVED || lcode == LCODE_RESERVED ||
				brx == BRX_BAD || srx == SRX_BAD)
			return r;
		is_v1 = (vcode == VCODE_1);
		mono = (w[7:6] == CM_MONO);
		r.ver = (vcode == VCODE_25) ? VER_25 : ((vcode == VCODE_2) ? VER_2 : VER_1);
		case (lcode)
			LCODE_L3: begin
				r.lay = 2'd3;
				spf = is_v1 ? 1152 : 576;
			end
			LCODE_L2: begin
				r.lay = 2'd2;
				spf = 1152;
			end
			default: begin
				r.lay = 2'd1;
				spf = 384;
			end
		endcase
		fs = RATE_HZ[srx*16 +: 16];
		if (brx != BRX_FREE) begin
			rate = is_v1 ? KBPS_V1[brx*9 +: 9] : KBPS_V2[brx*9 +: 9];
			r.frame_bytes = 11'((144000 * rate) / fs + pad);
		end else begin
			// free format: rate derived from the padded slot count, size reported as 1
			if (is_v1)
				rate = ((spf / 4 - pad) * fs + 11) / 12;
			else
				rate = ((spf - pad) * fs + 143) / 144;
			r.frame_bytes = 11'd1;
		end
		r.ok = 1'b1;
		r.spf = 11'(spf);
		r.fs = 16'(fs);
		r.cm = w[7:6];
		r.nch = mono ? 2'd1 : 2'd2;
		r.xoff = is_v1 ? (mono ? 6'd21 : 6'd36) : (mono ? 6'd13 : 6'd21);
		r.kbps = 21'(rate);
		return r;
	endfunction

	function automatic logic [31:0] make_header(input logic [1:0] vc, input logic [1:0] lc,
			input logic [3:0] brx, input logic [1:0] srx, input logic pad,
			input logic [1:0] cm, input logic [31:0] noise);
		return {11'h7FF, vc, lc, noise[16], brx, srx, pad, noise[8], cm, noise[5:0]};
	endfunction

	function automatic logic [31:0] random_good_header();
		logic [1:0] vc;
		case ($urandom_range(0, 2))
			0:       vc = VCODE_25;
			1:       vc = VCODE_2;
			default: vc = VCODE_1;
		endcase
		return make_header(vc, 2'($urandom_range(1, 3)), 4'($urandom_range(0, 14)),
			2'($urandom_range(0, 2)), 1'($urandom), 2'($urandom), $urandom);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want, input logic [31:0] word);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d for header %h",
				name, got, want, word));
	endtask

	// offer one header word, wait for the transfer and queue its expected result
	task automatic send_header(input logic [31:0] w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		header_word <= w;
		@(posedge clk);
		while (in_stall) begin
			input_held++;
			@(posedge clk);
		end
		pending_frames.push_back('{word: w, info: decode_frame_header(w)});
		n_sent++;
	endtask

	task automatic test_field_extremes();
		send_header(32'h0000_0000);
		send_header(32'hFFFF_FFFF);
		// largest frame: mpeg-1, top bitrate, 32 kHz, padded
		send_header(make_header(VCODE_1, LCODE_L1, 4'd14, 2'd2, 1'b1, 2'd0, 32'hFFFF_FFFF));
		send_header(make_header(VCODE_25, LCODE_L3, 4'd1, 2'd1, 1'b0, CM_MONO, 32'h0));
		send_header(make_header(VCODE_2, LCODE_L2, 4'd14, 2'd0, 1'b1, 2'd2, 32'h0001_0100));
		send_header(make_header(VCODE_1, LCODE_L3, 4'd1, 2'd0, 1'b0, 2'd1, 32'h0000_003F));
	endtask

	task automatic test_rejects();
		logic [31:0] base;
		base = make_header(VCODE_1, LCODE_L2, 4'd9, 2'd0, 1'b0, 2'd0, 32'h0);
		send_header(base & ~32'h0020_0000);
		send_header(base & ~32'h8000_0000);
		send_header({base[31:21], VCODE_RESERVED, base[18:0]});
		send_header({base[31:19], LCODE_RESERVED, base[16:0]});
		send_header({base[31:16], BRX_BAD, base[11:0]});
		send_header({base[31:12], SRX_BAD, base[9:0]});
	endtask

	task automatic test_free_format();
		send_header(make_header(VCODE_1, LCODE_L1, BRX_FREE, 2'd1, 1'b1, 2'd0, 32'h0));
		send_header(make_header(VCODE_1, LCODE_L3, BRX_FREE, 2'd0, 1'b0, CM_MONO, 32'h0));
		send_header(make_header(VCODE_2, LCODE_L3, BRX_FREE, 2'd0, 1'b1, CM_MONO, 32'h0));
		send_header(make_header(VCODE_25, LCODE_L2, BRX_FREE, 2'd2, 1'b0, 2'd1, 32'h0));
		send_header(make_header(VCODE_2, LCODE_L1, BRX_FREE, 2'd1, 1'b1, 2'd2, 32'h0));
		send_header(make_header(VCODE_25, LCODE_L1, BRX_FREE, 2'd2, 1'b1, CM_MONO, 32'h0));
	endtask

	// receiver holds off for a long stretch while headers keep coming back to back
	task automatic test_backpressure();
		hold_req = 60;
		no_idle = 1'b1;
		repeat (30) send_header(random_good_header());
		no_idle = 1'b0;
	endtask

	task automatic test_random_headers(input int count);
		logic [31:0] w;
		int pick;
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= 400 && i < 480);
			pick = $urandom_range(0, 99);
			w = random_good_header();
			if (pick >= 97) begin
				w = $urandom;
			end else if (pick >= 90) begin
				w[21 + $urandom_range(0, 10)] = 1'b0;
			end else if (pick >= 78) begin
				case ($urandom_range(0, 3))
					0:       w[20:19] = VCODE_RESERVED;
					1:       w[18:17] = LCODE_RESERVED;
					2:       w[15:12] = BRX_BAD;
					default: w[11:10] = SRX_BAD;
				endcase
			end
			send_header(w);
		end
		no_idle = 1'b0;
	endtask

	// result side: random stall before each transfer, or a requested long hold
	initial begin
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("result transfer with no header pending");
			end else begin
				head = pending_frames.pop_front();
				check_field("valid_res", valid_res, head.info.ok, head.word);
				check_field("size_result", size_result, head.info.frame_bytes, head.word);
				check_field("version", version, head.info.ver, head.word);
				check_field("layer", layer, head.info.lay, head.word);
				check_field("samples_per_frame", samples_per_frame, head.info.spf, head.word);
				check_field("sample_rate", sample_rate, head.info.fs, head.word);
				check_field("channel_mode", channel_mode, head.info.cm, head.word);
				check_field("num_channels", num_channels, head.info.nch, head.word);
				check_field("xing_offset", xing_offset, head.info.xoff, head.word);
				check_field("bit_rate", bit_rate, head.info.kbps, head.word);
				if (!head.info.ok)
					n_reject++;
				else begin
					n_valid++;
					if (head.word[15:12] == BRX_FREE)
						n_free++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		header_word <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_rejects();
		test_free_format();
		test_backpressure();
		test_random_headers(850);
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("decoded %0d headers: %0d accepted (%0d free format), %0d rejected",
			n_sent, n_valid, n_free, n_reject);
		$display("input side held off for %0d cycles; %0d mismatches", input_held, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
